[hw/rtl/ipv4dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, codes and the character decoder of the dotted-quad validator.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned OCTET_W = 8;
  localparam int unsigned QUAD_LEN = 4;
  localparam int unsigned OCTET_MAX = 255;

  localparam logic [CHAR_W-1:0] CH_END = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP = 8'h58;

  localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_START = 3'd1;
  localparam logic [ERR_W-1:0] ERR_CHAR  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FEW   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_MANY  = 3'd5;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // Decode a character as a hex digit (0-9, a-f, A-F).
  function automatic digit_t hex_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] diff;
    d    = '0;
    diff = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      d.ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      d.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      d.ok = 1'b1;
    end
    d.val = diff[3:0];
    return d;
  endfunction

endpackage

[hw/rtl/ipv4dq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_if
// Valid/ready channels of the validator: character input and verdict output.
// ----------------------------------------------------------------------------
interface ipv4dq_ch_if;
  logic                            valid;
  logic                            ready;
  logic [ipv4dq_pkg::CHAR_W-1:0]   ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ipv4dq_res_if;
  logic                            valid;
  logic                            ready;
  logic                            valid_res;
  logic [ipv4dq_pkg::ERR_W-1:0]    error_code;
  logic [ipv4dq_pkg::OCTET_W-1:0]  octet0;
  logic [ipv4dq_pkg::OCTET_W-1:0]  octet1;
  logic [ipv4dq_pkg::OCTET_W-1:0]  octet2;
  logic [ipv4dq_pkg::OCTET_W-1:0]  octet3;

  modport source (output valid, output valid_res, output error_code,
                  output octet0, output octet1, output octet2, output octet3,
                  input ready);
  modport sink   (input valid, input valid_res, input error_code,
                  input octet0, input octet1, input octet2, input octet3,
                  output ready);
endinterface

[hw/rtl/ipv4_dotted_quad_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_validator
// Checks a character stream for a dotted-quad IPv4 address.
//
// chars carries one character per transfer; a zero byte ends the string.
// Every other character gives no result and, until an error, updates the
// scan state. The zero byte gives one transfer on res: valid_res, error_code (first error
// in string order) and the four octets, zero when the string is invalid.
// Tokens may be decimal, octal after a leading 0, or hex after 0x/0X.
//
// The verdict is registered and appears on res in the cycle after the zero byte is taken.
// Throughput: one character per cycle unless res stalls; the scan state is a single register
// stage updated by the decoder and the shift-and-add accumulator.
// A verdict held in the result register does not block input while res
// is ready; when res stalls, chars.ready drops until the verdict is taken.
// Reset (rst, synchronous) returns to the start of a string and drops any
// pending verdict. After each verdict the scan state starts over.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_validator (
  input  logic                 clk,
  input  logic                 rst,
  ipv4dq_ch_if.sink            chars,
  ipv4dq_res_if.source         res
);

  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_ZERO    = 3'd1;
  localparam logic [2:0] MODE_XPREFIX = 3'd2;
  localparam logic [2:0] MODE_HEX     = 3'd3;
  localparam logic [2:0] MODE_OCT     = 3'd4;
  localparam logic [2:0] MODE_DEC     = 3'd5;
  localparam logic [2:0] MODE_SKIP    = 3'd6;

  localparam logic [2:0] COUNT_FULL = 3'(ipv4dq_pkg::QUAD_LEN);
  localparam logic [8:0] VALUE_SAT  = 9'(ipv4dq_pkg::OCTET_MAX + 1);
  localparam logic [12:0] VALUE_MAX = 13'(ipv4dq_pkg::OCTET_MAX);

  logic [2:0] scan_mode;
  logic [8:0] token_value;
  logic       value_over;
  logic [2:0] token_count;
  logic [ipv4dq_pkg::OCTET_W-1:0] octet_store [ipv4dq_pkg::QUAD_LEN];
  logic [ipv4dq_pkg::ERR_W-1:0]   first_error;

  logic [2:0] scan_mode_next;
  logic [8:0] token_value_next;
  logic       value_over_next;
  logic [2:0] token_count_next;
  logic [ipv4dq_pkg::OCTET_W-1:0] octet_store_next [ipv4dq_pkg::QUAD_LEN];
  logic [ipv4dq_pkg::ERR_W-1:0]   first_error_next;

  logic                           res_valid;
  logic                           valid_res;
  logic [ipv4dq_pkg::ERR_W-1:0]   error_code;
  logic [ipv4dq_pkg::OCTET_W-1:0] octet [ipv4dq_pkg::QUAD_LEN];

  logic                           res_valid_next;
  logic                           valid_res_next;
  logic [ipv4dq_pkg::ERR_W-1:0]   error_code_next;
  logic [ipv4dq_pkg::OCTET_W-1:0] octet_next [ipv4dq_pkg::QUAD_LEN];

  logic                in_fire;
  logic                is_end;
  ipv4dq_pkg::digit_t  dig;
  logic                ok8;
  logic                ok10;
  logic                ok16;
  logic [12:0]         acc8;
  logic [12:0]         acc10;
  logic [12:0]         acc16;

  assign in_fire     = chars.valid && chars.ready;
  assign chars.ready = !res_valid || res.ready;
  assign is_end      = (chars.ch == ipv4dq_pkg::CH_END);

  assign dig  = ipv4dq_pkg::hex_digit(chars.ch);
  assign ok8  = dig.ok && (dig.val < 4'd8);
  assign ok10 = dig.ok && (dig.val < 4'd10);
  assign ok16 = dig.ok;
  assign acc8  = {1'b0, token_value, 3'b000} + {9'd0, dig.val};
  assign acc10 = {1'b0, token_value, 3'b000} + {3'b000, token_value, 1'b0}
               + {9'd0, dig.val};
  assign acc16 = {token_value, 4'b0000} + {9'd0, dig.val};

  always_comb begin
    logic [12:0] acc;
    logic        do_acc;
    logic [ipv4dq_pkg::ERR_W-1:0] fail_code;
    logic        do_fail;
    logic [ipv4dq_pkg::ERR_W-1:0] verdict;

    scan_mode_next   = scan_mode;
    token_value_next = token_value;
    value_over_next  = value_over;
    token_count_next = token_count;
    octet_store_next = octet_store;
    first_error_next = first_error;
    res_valid_next   = res_valid && !res.ready;
    valid_res_next   = valid_res;
    error_code_next  = error_code;
    octet_next       = octet;
    acc       = '0;
    do_acc    = 1'b0;
    fail_code = ipv4dq_pkg::ERR_NONE;
    do_fail   = 1'b0;
    verdict   = ipv4dq_pkg::ERR_NONE;

    if (in_fire && scan_mode != MODE_SKIP) begin
      if (is_end || chars.ch == ipv4dq_pkg::CH_DOT) begin
        case (scan_mode)
          MODE_ZERO, MODE_HEX, MODE_OCT, MODE_DEC: begin
            if (value_over) begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_RANGE;
            end else begin
              octet_store_next[token_count[1:0]] = token_value[7:0];
              if (token_count < COUNT_FULL) begin
                token_count_next = token_count + 3'd1;
              end
            end
          end
          MODE_XPREFIX: begin
            do_fail   = 1'b1;
            fail_code = ipv4dq_pkg::ERR_CHAR;
          end
          default: begin
          end
        endcase
        if (!do_fail) begin
          scan_mode_next   = MODE_BETWEEN;
          token_value_next = '0;
          value_over_next  = 1'b0;
        end
      end else begin
        case (scan_mode)
          MODE_BETWEEN: begin
            if (token_count >= COUNT_FULL) begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_MANY;
            end else if (chars.ch == ipv4dq_pkg::CH_ZERO) begin
              token_value_next = '0;
              value_over_next  = 1'b0;
              scan_mode_next   = MODE_ZERO;
            end else if (chars.ch inside {[8'h31:8'h39]}) begin
              token_value_next = {5'd0, dig.val};
              value_over_next  = 1'b0;
              scan_mode_next   = MODE_DEC;
            end else begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_START;
            end
          end
          MODE_ZERO: begin
            if (chars.ch == ipv4dq_pkg::CH_X_LO || chars.ch == ipv4dq_pkg::CH_X_UP) begin
              scan_mode_next = MODE_XPREFIX;
            end else if (ok8) begin
              do_acc         = 1'b1;
              acc            = acc8;
              scan_mode_next = MODE_OCT;
            end else begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_CHAR;
            end
          end
          MODE_XPREFIX, MODE_HEX: begin
            if (ok16) begin
              do_acc         = 1'b1;
              acc            = acc16;
              scan_mode_next = MODE_HEX;
            end else begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_CHAR;
            end
          end
          MODE_OCT: begin
            if (ok8) begin
              do_acc = 1'b1;
              acc    = acc8;
            end else begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_CHAR;
            end
          end
          MODE_DEC: begin
            if (ok10) begin
              do_acc = 1'b1;
              acc    = acc10;
            end else begin
              do_fail   = 1'b1;
              fail_code = ipv4dq_pkg::ERR_CHAR;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // saturate the token just past the octet range
    if (do_acc) begin
      if (acc > VALUE_MAX) begin
        value_over_next  = 1'b1;
        token_value_next = VALUE_SAT;
      end else begin
        token_value_next = acc[8:0];
      end
    end

    if (do_fail) begin
      scan_mode_next = MODE_SKIP;
      if (first_error == ipv4dq_pkg::ERR_NONE) begin
        first_error_next = fail_code;
      end
    end

    if (in_fire && is_end) begin
      verdict = first_error_next;
      if (verdict == ipv4dq_pkg::ERR_NONE && token_count_next != COUNT_FULL) begin
        verdict = ipv4dq_pkg::ERR_FEW;
      end
      res_valid_next  = 1'b1;
      valid_res_next  = (verdict == ipv4dq_pkg::ERR_NONE);
      error_code_next = verdict;
      for (int i = 0; i < int'(ipv4dq_pkg::QUAD_LEN); i++) begin
        octet_next[i] = valid_res_next ? octet_store_next[i] : '0;
      end
      scan_mode_next   = MODE_BETWEEN;
      token_value_next = '0;
      value_over_next  = 1'b0;
      token_count_next = '0;
      first_error_next = ipv4dq_pkg::ERR_NONE;
      for (int i = 0; i < int'(ipv4dq_pkg::QUAD_LEN); i++) begin
        octet_store_next[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_BETWEEN;
      token_value <= '0;
      value_over  <= 1'b0;
      token_count <= '0;
      first_error <= ipv4dq_pkg::ERR_NONE;
      res_valid   <= 1'b0;
      for (int i = 0; i < int'(ipv4dq_pkg::QUAD_LEN); i++) begin
        octet_store[i] <= '0;
      end
    end else begin
      scan_mode   <= scan_mode_next;
      token_value <= token_value_next;
      value_over  <= value_over_next;
      token_count <= token_count_next;
      first_error <= first_error_next;
      res_valid   <= res_valid_next;
      octet_store <= octet_store_next;
    end
  end

  always_ff @(posedge clk) begin
    valid_res  <= valid_res_next;
    error_code <= error_code_next;
    octet      <= octet_next;
  end

  assign res.valid      = res_valid;
  assign res.valid_res  = valid_res;
  assign res.error_code = error_code;
  assign res.octet0     = octet[0];
  assign res.octet1     = octet[1];
  assign res.octet2     = octet[2];
  assign res.octet3     = octet[3];

  a_verdict_follows_end : assert property (@(posedge clk) disable iff (rst)
    in_fire && is_end |=> res_valid)
    else $error("verdict missing after end of string");

  a_valid_matches_code : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (valid_res == (error_code == ipv4dq_pkg::ERR_NONE)))
    else $error("valid_res disagrees with error_code");

  a_invalid_zero_octets : assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> (octet[0] == '0 && octet[1] == '0 &&
                                 octet[2] == '0 && octet[3] == '0))
    else $error("invalid verdict carries octets");

  a_error_means_skip : assert property (@(posedge clk) disable iff (rst)
    first_error != ipv4dq_pkg::ERR_NONE |-> scan_mode == MODE_SKIP)
    else $error("error recorded while still scanning");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    token_count <= COUNT_FULL)
    else $error("token count past four");

endmodule
